>>> rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define AST_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define AST_CLK_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define AST_CLK(lbl, clk, rst, prop)
`define AST_CLK_NR(lbl, clk, prop)
`endif
`endif

>>> rtl/cau_pkg.sv
// Shared types and constants of the complex arithmetic unit
`timescale 1ns / 1ps
package cau_pkg;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_EQ  = 3'd4,
    OP_MAG = 3'd5
  } op_t;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_DZ  = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  typedef struct packed {
    logic valid;
    op_t  op;
    logic dz;
    logic eq;
  } ctrl_t;
endpackage

>>> rtl/cau_front.sv
// Operand products, sums and setup of the iteration chain
`timescale 1ns / 1ps
module cau_front import cau_pkg::*; #(
  parameter int W = DATA_WIDTH_DEF,
  parameter int F = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [2:0]           opcode,
  input  logic signed [W-1:0]  a_re,
  input  logic signed [W-1:0]  a_im,
  input  logic signed [W-1:0]  b_re,
  input  logic signed [W-1:0]  b_im,
  output ctrl_t                ctrl,
  output logic                 neg_re,
  output logic                 neg_im,
  output logic [2*W+F-1:0]     num_re,
  output logic [2*W+F-1:0]     num_im,
  output logic [2*W+F-1:0]     q_re,
  output logic [2*W+F-1:0]     q_im,
  output logic [2*W-1:0]       den
);
  localparam int N = 2 * W + F;
  localparam int RW = 2 * W + 1;

  logic v1;
  op_t op1;
  logic eq1;
  logic signed [2*W-1:0] p0, p1, p2, p3, p4, p5;
  logic signed [W:0] sum_re1, sum_im1;
  logic mag;
  logic signed [W:0] as_re, as_im;
  logic signed [RW-1:0] sre, sim;
  logic [RW-1:0] mre, mim;
  logic [2*W-1:0] den_c;
  logic nre, nim;
  logic [N-1:0] nre_c, nim_c, qre_c, qim_c;

  assign mag = op_t'(opcode) == OP_MAG;

  always_comb begin
    if (op_t'(opcode) == OP_SUB) begin
      as_re = $signed({a_re[W-1], a_re}) - $signed({b_re[W-1], b_re});
      as_im = $signed({a_im[W-1], a_im}) - $signed({b_im[W-1], b_im});
    end else begin
      as_re = $signed({a_re[W-1], a_re}) + $signed({b_re[W-1], b_re});
      as_im = $signed({a_im[W-1], a_im}) + $signed({b_im[W-1], b_im});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      op1 <= op_t'(opcode);
      eq1 <= (a_re == b_re) && (a_im == b_im);
      p0 <= a_re * (mag ? a_re : b_re);
      p1 <= a_im * (mag ? a_im : b_im);
      p2 <= a_re * b_im;
      p3 <= a_im * b_re;
      p4 <= b_re * b_re;
      p5 <= b_im * b_im;
      sum_re1 <= as_re;
      sum_im1 <= as_im;
    end
  end

  always_comb begin
    sre = '0;
    sim = '0;
    case (op1)
      OP_ADD, OP_SUB: begin
        sre = RW'(sum_re1);
        sim = RW'(sum_im1);
      end
      OP_MUL: begin
        sre = RW'(p0) - RW'(p1);
        sim = RW'(p2) + RW'(p3);
      end
      OP_DIV: begin
        sre = RW'(p0) + RW'(p1);
        sim = RW'(p3) - RW'(p2);
      end
      OP_MAG: begin
        sre = RW'(p0) + RW'(p1);
      end
      default: begin
        sre = '0;
      end
    endcase
    nre = sre[RW-1];
    nim = sim[RW-1];
    mre = nre ? RW'(-sre) : RW'(sre);
    mim = nim ? RW'(-sim) : RW'(sim);
    den_c = $unsigned(p4) + $unsigned(p5);
    nre_c = '0;
    nim_c = '0;
    qre_c = '0;
    qim_c = '0;
    case (op1)
      OP_ADD, OP_SUB: begin
        qre_c = N'(mre);
        qim_c = N'(mim);
      end
      OP_MUL: begin
        qre_c = N'(mre >> F);
        qim_c = N'(mim >> F);
      end
      OP_DIV, OP_MAG: begin
        nre_c = N'(mre[2*W-1:0]) << F;
        nim_c = N'(mim[2*W-1:0]) << F;
      end
      default: begin
        qre_c = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.valid <= 1'b0;
    end else if (en) begin
      ctrl.valid <= v1;
    end
    if (en) begin
      ctrl.op <= op1;
      ctrl.dz <= (op1 == OP_DIV) && (den_c == '0);
      ctrl.eq <= (op1 == OP_EQ) && eq1;
      neg_re <= nre;
      neg_im <= nim;
      num_re <= nre_c;
      num_im <= nim_c;
      q_re <= qre_c;
      q_im <= qim_c;
      den <= den_c;
    end
  end
endmodule

>>> rtl/cau_iter_stage.sv
// One quotient bit of both divides, or one root bit of the magnitude if K < W
`timescale 1ns / 1ps
module cau_iter_stage import cau_pkg::*; #(
  parameter int W = DATA_WIDTH_DEF,
  parameter int F = FRAC_BITS_DEF,
  parameter int K = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  ctrl_t             ctrl_in,
  input  logic              neg_re_in,
  input  logic              neg_im_in,
  input  logic [2*W+F-1:0]  num_re_in,
  input  logic [2*W+F-1:0]  num_im_in,
  input  logic [2*W+F-1:0]  q_re_in,
  input  logic [2*W+F-1:0]  q_im_in,
  input  logic [2*W:0]      rem_re_in,
  input  logic [2*W:0]      rem_im_in,
  input  logic [2*W-1:0]    den_in,
  output ctrl_t             ctrl_out,
  output logic              neg_re_out,
  output logic              neg_im_out,
  output logic [2*W+F-1:0]  num_re_out,
  output logic [2*W+F-1:0]  num_im_out,
  output logic [2*W+F-1:0]  q_re_out,
  output logic [2*W+F-1:0]  q_im_out,
  output logic [2*W:0]      rem_re_out,
  output logic [2*W:0]      rem_im_out,
  output logic [2*W-1:0]    den_out
);
  localparam int N = 2 * W + F;
  localparam int RW = 2 * W + 1;
  localparam bit SQ = K < W;

  logic [RW-1:0] rre, rim, trial, dext;
  logic gre, gim;
  logic [N-1:0] nre, nim, qre, qim;
  logic [RW-1:0] rre_n, rim_n;

  always_comb begin
    dext = RW'(den_in);
    nre = num_re_in;
    nim = num_im_in;
    qre = q_re_in;
    qim = q_im_in;
    rre_n = rem_re_in;
    rim_n = rem_im_in;
    rre = '0;
    rim = '0;
    trial = '0;
    gre = 1'b0;
    gim = 1'b0;
    if (ctrl_in.op == OP_DIV) begin
      rre = {rem_re_in[2*W-1:0], num_re_in[N-1]};
      rim = {rem_im_in[2*W-1:0], num_im_in[N-1]};
      gre = rre >= dext;
      gim = rim >= dext;
      rre_n = gre ? rre - dext : rre;
      rim_n = gim ? rim - dext : rim;
      qre = {q_re_in[N-2:0], gre};
      qim = {q_im_in[N-2:0], gim};
      nre = num_re_in << 1;
      nim = num_im_in << 1;
    end else if (ctrl_in.op == OP_MAG && SQ) begin
      rre = {rem_re_in[2*W-2:0], num_re_in[N-1:N-2]};
      trial = RW'({q_re_in[W-1:0], 2'b01});
      gre = rre >= trial;
      rre_n = gre ? rre - trial : rre;
      qre = {q_re_in[N-2:0], gre};
      nre = num_re_in << 2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out.valid <= 1'b0;
    end else if (en) begin
      ctrl_out.valid <= ctrl_in.valid;
    end
    if (en) begin
      ctrl_out.op <= ctrl_in.op;
      ctrl_out.dz <= ctrl_in.dz;
      ctrl_out.eq <= ctrl_in.eq;
      neg_re_out <= neg_re_in;
      neg_im_out <= neg_im_in;
      num_re_out <= nre;
      num_im_out <= nim;
      q_re_out <= qre;
      q_im_out <= qim;
      rem_re_out <= rre_n;
      rem_im_out <= rim_n;
      den_out <= den_in;
    end
  end
endmodule

>>> rtl/cau_back.sv
// Saturation, sign and status of the result item
`timescale 1ns / 1ps
module cau_back import cau_pkg::*; #(
  parameter int W = DATA_WIDTH_DEF,
  parameter int F = FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  ctrl_t               ctrl,
  input  logic                neg_re,
  input  logic                neg_im,
  input  logic [2*W+F-1:0]    q_re,
  input  logic [2*W+F-1:0]    q_im,
  output logic                out_valid,
  output logic signed [W-1:0] res_re,
  output logic signed [W-1:0] res_im,
  output logic                is_equal,
  output logic [1:0]          status
);
  localparam int N = 2 * W + F;
  localparam logic [N-1:0] NEG_MAX = N'(1) << (W - 1);
  localparam logic [N-1:0] POS_MAX = NEG_MAX - N'(1);

  logic ov_re, ov_im;
  logic [N-1:0] v_re, v_im;
  logic [W-1:0] o_re, o_im;
  logic [1:0] st;

  always_comb begin
    ov_re = neg_re ? (q_re > NEG_MAX) : (q_re > POS_MAX);
    ov_im = neg_im ? (q_im > NEG_MAX) : (q_im > POS_MAX);
    v_re = ov_re ? (neg_re ? NEG_MAX : POS_MAX) : q_re;
    v_im = ov_im ? (neg_im ? NEG_MAX : POS_MAX) : q_im;
    o_re = neg_re ? W'(-v_re[W-1:0]) : v_re[W-1:0];
    o_im = neg_im ? W'(-v_im[W-1:0]) : v_im[W-1:0];
    st = (ov_re || ov_im) ? ST_SAT : ST_OK;
    if (ctrl.dz) begin
      o_re = '0;
      o_im = '0;
      st = ST_DZ;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= ctrl.valid;
    end
    if (en) begin
      res_re <= o_re;
      res_im <= o_im;
      is_equal <= ctrl.eq;
      status <= st;
    end
  end
endmodule

>>> rtl/complex_arithmetic_unit.sv
// Complex arithmetic unit in signed fixed point, top level
// Usage:
//   Input channel in_valid/in_ready carries opcode, a_re, a_im, b_re, b_im.
//   Output channel out_valid/out_ready carries res_re, res_im, is_equal,
//   status. Opcodes: add, subtract, multiply, divide, equal, magnitude of a.
//   Throughput: one item per cycle, every opcode, while out_ready does not stall the output.
//   Stages: one product stage, one sum stage, one stage per quotient bit
//   of the restoring divider (the root unit shares the first DATA_WIDTH of
//   those stages), one saturation stage.
//   Multiply and divide truncate toward zero; magnitude is the floor root.
//   Overflowing parts clamp and give status 2; a zero divisor gives a zero
//   result and status 1.
//   Reset clears all valid bits and holds in_ready low; the pipeline is
//   empty after reset.
//   When the receiver holds out_ready low with a result waiting, the whole
//   pipeline holds, bubbles included, and in_ready drops.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module complex_arithmetic_unit import cau_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [2:0]                   opcode,
  input  logic signed [DATA_WIDTH-1:0] a_re,
  input  logic signed [DATA_WIDTH-1:0] a_im,
  input  logic signed [DATA_WIDTH-1:0] b_re,
  input  logic signed [DATA_WIDTH-1:0] b_im,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] res_re,
  output logic signed [DATA_WIDTH-1:0] res_im,
  output logic                         is_equal,
  output logic [1:0]                   status
);
  localparam int W = DATA_WIDTH;
  localparam int F = FRAC_BITS;
  localparam int N = 2 * W + F;

  logic en;
  ctrl_t ctrl_s [0:N];
  logic neg_re_s [0:N];
  logic neg_im_s [0:N];
  logic [N-1:0] num_re_s [0:N];
  logic [N-1:0] num_im_s [0:N];
  logic [N-1:0] q_re_s [0:N];
  logic [N-1:0] q_im_s [0:N];
  logic [2*W:0] rem_re_s [0:N];
  logic [2*W:0] rem_im_s [0:N];
  logic [2*W-1:0] den_s [0:N];

  assign en = !out_valid || out_ready;
  assign in_ready = en && !rst;
  assign rem_re_s[0] = '0;
  assign rem_im_s[0] = '0;

  cau_front #(.W(W), .F(F)) u_front (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_valid), .opcode(opcode),
    .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
    .ctrl(ctrl_s[0]), .neg_re(neg_re_s[0]), .neg_im(neg_im_s[0]),
    .num_re(num_re_s[0]), .num_im(num_im_s[0]),
    .q_re(q_re_s[0]), .q_im(q_im_s[0]), .den(den_s[0])
  );

  for (genvar k = 0; k < N; k++) begin : g_iter
    cau_iter_stage #(.W(W), .F(F), .K(k)) u_stage (
      .clk(clk), .rst(rst), .en(en),
      .ctrl_in(ctrl_s[k]), .neg_re_in(neg_re_s[k]), .neg_im_in(neg_im_s[k]),
      .num_re_in(num_re_s[k]), .num_im_in(num_im_s[k]),
      .q_re_in(q_re_s[k]), .q_im_in(q_im_s[k]),
      .rem_re_in(rem_re_s[k]), .rem_im_in(rem_im_s[k]), .den_in(den_s[k]),
      .ctrl_out(ctrl_s[k+1]), .neg_re_out(neg_re_s[k+1]),
      .neg_im_out(neg_im_s[k+1]),
      .num_re_out(num_re_s[k+1]), .num_im_out(num_im_s[k+1]),
      .q_re_out(q_re_s[k+1]), .q_im_out(q_im_s[k+1]),
      .rem_re_out(rem_re_s[k+1]), .rem_im_out(rem_im_s[k+1]),
      .den_out(den_s[k+1])
    );
  end

  cau_back #(.W(W), .F(F)) u_back (
    .clk(clk), .rst(rst), .en(en), .ctrl(ctrl_s[N]),
    .neg_re(neg_re_s[N]), .neg_im(neg_im_s[N]),
    .q_re(q_re_s[N]), .q_im(q_im_s[N]),
    .out_valid(out_valid), .res_re(res_re), .res_im(res_im),
    .is_equal(is_equal), .status(status)
  );

  `AST_CLK(a_dz_zero, clk, rst,
    out_valid && status == ST_DZ |-> res_re == '0 && res_im == '0)
  `AST_CLK(a_eq_clean, clk, rst,
    out_valid && is_equal |-> status == ST_OK && res_re == '0 && res_im == '0)
  `AST_CLK(a_stall_blocks, clk, rst, out_valid && !out_ready |-> !in_ready)
endmodule
